### rtl/ptt_pkg.sv
// Shared constants, codes and types of the periodic timer table.
package ptt_pkg;

    localparam int TABLE_SIZE = 16;
    localparam int ID_W       = 8;
    localparam int PER_W      = 16;
    localparam int MODE_W     = 2;
    localparam int STAT_W     = 2;
    localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

    // input modes
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_START = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STOP  = 2'd2;

    // result status
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // operations carried by the token through the cells
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SCAN   = 2'd1;  // duplicate-id search before a start
    localparam logic [1:0] OP_INSERT = 2'd2;  // take the lowest free slot
    localparam logic [1:0] OP_STOP   = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [1:0]       op;
        logic [ID_W-1:0]  id;
        logic [PER_W-1:0] period;
        logic             hit;   // dup found / slot taken / entry freed
    } t_tok;

    typedef struct packed {
        logic            fire;
        logic [ID_W-1:0] id;    // zero unless fire
    } t_fire;

endpackage

### rtl/ptt_in_if.sv
// Command channel of the periodic timer table.
interface ptt_in_if;
    logic                        valid;
    logic                        ready;
    logic [ptt_pkg::MODE_W-1:0]  mode;
    logic [ptt_pkg::ID_W-1:0]    task_id;
    logic [ptt_pkg::PER_W-1:0]   period;

    modport source (output valid, mode, task_id, period, input ready);
    modport sink   (input valid, mode, task_id, period, output ready);
endinterface

### rtl/ptt_out_if.sv
// Result channel of the periodic timer table.
interface ptt_out_if;
    logic                        valid;
    logic                        ready;
    logic                        fired;
    logic [ptt_pkg::ID_W-1:0]    fired_id;
    logic [ptt_pkg::STAT_W-1:0]  status;
    logic [ptt_pkg::CNT_W-1:0]   active_entries;
    logic                        last;

    modport source (output valid, fired, fired_id, status, active_entries, last,
                    input ready);
    modport sink   (input valid, fired, fired_id, status, active_entries, last,
                    output ready);
endinterface

### rtl/periodic_task_timer_table.sv
// Top level of the periodic timer table: token chain of entry cells and result control.
//
//  channel  | dir | carries                                              | transfer
//  ---------+-----+------------------------------------------------------+-----------------
//  i_cmd    | in  | mode, task_id, period                                | valid && ready
//  o_res    | out | fired, fired_id, status, active_entries, last        | valid && ready
//
// Flow: a command token walks the row of TABLE_SIZE cells, one cell per cycle while
//   the chain is not stalled. Tick and stop take one pass, a start a duplicate scan
//   followed by an insert pass. Start on a full table, stop on an empty one and
//   mode 3 answer directly without a token. One item is in the chain at a time.
// Reset: synchronous, active low; clears valid bits of all entries, the entry count,
//   the token registers and the result valid bit. Entry payload is left as is.
// Stalls: the whole chain freezes while the result register holds an untaken result.
module periodic_task_timer_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ptt_in_if.sink     i_cmd,
    ptt_out_if.source  o_res
);

    localparam int N = ptt_pkg::TABLE_SIZE;

    // chain of tokens: tok[0] is the inject register, tok[N] leaves the last cell
    ptt_pkg::t_tok              tok [N+1];
    ptt_pkg::t_fire             fire [N];
    logic [N-1:0]               used_vec;
    logic [N:0]                 tok_valid;

    ptt_pkg::t_tok              r_inj, n_inj;
    logic                       r_busy, n_busy;
    logic [ptt_pkg::CNT_W-1:0]  r_count, n_count;
    // a fire result held back until we know whether it is the last one
    logic                       r_pend, n_pend;
    logic [ptt_pkg::ID_W-1:0]   r_pend_id, n_pend_id;

    // result register
    logic                       r_res_valid, n_res_valid;
    logic                       r_fired, n_fired;
    logic [ptt_pkg::ID_W-1:0]   r_fired_id, n_fired_id;
    logic [ptt_pkg::STAT_W-1:0] r_status, n_status;
    logic [ptt_pkg::CNT_W-1:0]  r_active, n_active;
    logic                       r_last, n_last;

    logic                       adv;
    logic                       accept;
    logic                       fire_any;
    logic [ptt_pkg::ID_W-1:0]   fire_id;
    ptt_pkg::t_tok              tail;

    // chain moves only when the result register can take a new result
    assign adv         = !r_res_valid || o_res.ready;
    assign i_cmd.ready = !r_busy && adv;
    assign accept      = i_cmd.valid && i_cmd.ready;

    assign tok[0] = r_inj;
    assign tail   = tok[N];

    for (genvar g = 0; g < N; g++) begin : g_cell
        ptt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1]),
            .o_fire  (fire[g]),
            .o_used  (used_vec[g])
        );
    end

    // only one cell sees the token, so an OR picks its fire report
    always_comb begin
        fire_any = 1'b0;
        fire_id  = '0;
        for (int k = 0; k < N; k++) begin
            fire_any = fire_any | fire[k].fire;
            fire_id  = fire_id | fire[k].id;
        end
        for (int k = 0; k <= N; k++) begin
            tok_valid[k] = tok[k].valid;
        end
    end

    always_comb begin
        n_inj       = r_inj;
        n_busy      = r_busy;
        n_count     = r_count;
        n_pend      = r_pend;
        n_pend_id   = r_pend_id;
        n_res_valid = r_res_valid && !o_res.ready;
        n_fired     = r_fired;
        n_fired_id  = r_fired_id;
        n_status    = r_status;
        n_active    = r_active;
        n_last      = r_last;

        if (adv) begin
            n_inj.valid = 1'b0;

            // new command
            if (accept) begin
                n_inj.id     = i_cmd.task_id;
                n_inj.period = i_cmd.period;
                n_inj.hit    = 1'b0;
                case (i_cmd.mode)
                    ptt_pkg::MODE_TICK: begin
                        n_inj.valid = 1'b1;
                        n_inj.op    = ptt_pkg::OP_TICK;
                        n_busy      = 1'b1;
                    end
                    ptt_pkg::MODE_START: begin
                        if (r_count == ptt_pkg::CNT_W'(N)) begin
                            n_res_valid = 1'b1;
                            n_fired     = 1'b0;
                            n_fired_id  = '0;
                            n_status    = ptt_pkg::ST_FULL;
                            n_active    = r_count;
                            n_last      = 1'b1;
                        end else begin
                            n_inj.valid = 1'b1;
                            n_inj.op    = ptt_pkg::OP_SCAN;
                            n_busy      = 1'b1;
                        end
                    end
                    ptt_pkg::MODE_STOP: begin
                        if (r_count == '0) begin
                            n_res_valid = 1'b1;
                            n_fired     = 1'b0;
                            n_fired_id  = '0;
                            n_status    = ptt_pkg::ST_EMPTY;
                            n_active    = r_count;
                            n_last      = 1'b1;
                        end else begin
                            n_inj.valid = 1'b1;
                            n_inj.op    = ptt_pkg::OP_STOP;
                            n_busy      = 1'b1;
                        end
                    end
                    default: begin  // unused mode: plain ok
                        n_res_valid = 1'b1;
                        n_fired     = 1'b0;
                        n_fired_id  = '0;
                        n_status    = ptt_pkg::ST_OK;
                        n_active    = r_count;
                        n_last      = 1'b1;
                    end
                endcase
            end

            // a cell fired: release the one held back, hold this one
            if (fire_any) begin
                if (r_pend) begin
                    n_res_valid = 1'b1;
                    n_fired     = 1'b1;
                    n_fired_id  = r_pend_id;
                    n_status    = ptt_pkg::ST_OK;
                    n_active    = r_count;
                    n_last      = 1'b0;
                end
                n_pend    = 1'b1;
                n_pend_id = fire_id;
            end

            // token leaves the row
            if (tail.valid) begin
                n_res_valid = 1'b1;
                n_fired     = 1'b0;
                n_fired_id  = '0;
                n_status    = ptt_pkg::ST_OK;
                n_active    = r_count;
                n_last      = 1'b1;
                n_busy      = 1'b0;
                case (tail.op)
                    ptt_pkg::OP_TICK: begin
                        n_fired    = r_pend;
                        n_fired_id = r_pend ? r_pend_id : '0;
                        n_pend     = 1'b0;
                    end
                    ptt_pkg::OP_SCAN: begin
                        if (!tail.hit) begin
                            // no duplicate: second pass takes the lowest free slot
                            n_res_valid = 1'b0;
                            n_busy      = 1'b1;
                            n_inj       = tail;
                            n_inj.op    = ptt_pkg::OP_INSERT;
                        end
                    end
                    ptt_pkg::OP_INSERT: begin
                        n_count  = r_count + ptt_pkg::CNT_W'(1);
                        n_active = r_count + ptt_pkg::CNT_W'(1);
                    end
                    default: begin  // stop
                        n_count  = r_count - ptt_pkg::CNT_W'(tail.hit);
                        n_active = r_count - ptt_pkg::CNT_W'(tail.hit);
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inj       <= '0;
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_inj       <= n_inj;
            r_busy      <= n_busy;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_res_valid <= n_res_valid;
        end
        r_pend_id  <= n_pend_id;
        r_fired    <= n_fired;
        r_fired_id <= n_fired_id;
        r_status   <= n_status;
        r_active   <= n_active;
        r_last     <= n_last;
    end

    assign o_res.valid          = r_res_valid;
    assign o_res.fired          = r_fired;
    assign o_res.fired_id       = r_fired_id;
    assign o_res.status         = r_status;
    assign o_res.active_entries = r_active;
    assign o_res.last           = r_last;

    // at most one token anywhere in the row
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(tok_valid) <= 1)
        else $error("more than one token in the cell row");

    // entry count never exceeds the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ptt_pkg::CNT_W'(N))
        else $error("entry count above table size");

    // between items the count agrees with the cells' valid bits
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> ($countones(used_vec) == int'(r_count)))
        else $error("entry count out of step with cell valid bits");

    // a token in flight means the block is busy
    a_token_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tok_valid != '0) |-> r_busy)
        else $error("token in flight while idle");

    // a held fire result only exists while a tick walks the row
    a_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_busy)
        else $error("held fire result outside a tick");

endmodule

### rtl/ptt_cell.sv
// One timer entry; processes the passing token and hands it to the next cell.
module ptt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  ptt_pkg::t_tok  i_tok,
    output ptt_pkg::t_tok  o_tok,
    output ptt_pkg::t_fire o_fire,
    output logic           o_used
);

    logic                      r_used, n_used;
    logic [ptt_pkg::ID_W-1:0]  r_id, n_id;
    logic [ptt_pkg::PER_W-1:0] r_period, n_period;
    logic [ptt_pkg::PER_W-1:0] r_cnt, n_cnt;
    ptt_pkg::t_tok             r_tok, n_tok;
    logic [ptt_pkg::PER_W-1:0] cnt_inc;
    logic                      act;
    logic                      id_match;

    assign act      = i_adv && i_tok.valid;
    assign cnt_inc  = r_cnt + ptt_pkg::PER_W'(1);
    assign id_match = r_used && (r_id == i_tok.id);

    always_comb begin
        n_used   = r_used;
        n_id     = r_id;
        n_period = r_period;
        n_cnt    = r_cnt;
        n_tok    = r_tok;
        o_fire   = '0;
        if (i_adv) begin
            n_tok = i_tok;
        end
        if (act) begin
            case (i_tok.op)
                ptt_pkg::OP_TICK: begin
                    if (r_used) begin
                        if (cnt_inc == r_period) begin
                            n_cnt       = '0;
                            o_fire.fire = 1'b1;
                            o_fire.id   = r_id;
                        end else begin
                            n_cnt = cnt_inc;
                        end
                    end
                end
                ptt_pkg::OP_SCAN: begin
                    if (id_match) n_tok.hit = 1'b1;
                end
                ptt_pkg::OP_INSERT: begin
                    if (!r_used && !i_tok.hit) begin
                        n_used    = 1'b1;
                        n_id      = i_tok.id;
                        n_period  = i_tok.period;
                        n_cnt     = ptt_pkg::PER_W'(1);
                        n_tok.hit = 1'b1;
                    end
                end
                default: begin  // stop
                    if (id_match && !i_tok.hit) begin
                        n_used    = 1'b0;
                        n_tok.hit = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_tok  <= '0;
        end else begin
            r_used <= n_used;
            r_tok  <= n_tok;
        end
        r_id     <= n_id;
        r_period <= n_period;
        r_cnt    <= n_cnt;
    end

    assign o_tok  = r_tok;
    assign o_used = r_used;

endmodule
